/* rtl/mpab_pkg.sv */
// shared types and constants for the mains period averaging led bargraph
// no dependencies; used by every module of the block except mpab_div
package mpab_pkg;

    localparam int LED_COUNT_DEF    = 9;
    localparam int COUNTER_BITS_DEF = 16;

    localparam int PERIODS_W = 8;
    localparam int NOMINAL_W = 16;
    localparam int STEP_W    = 16;
    localparam int AVG_W     = 16;
    localparam int IN_W      = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

    localparam logic [PERIODS_W-1:0] PERIODS_RESET = 8'd50;
    localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 16'd30000;
    localparam logic [STEP_W-1:0]    STEP_RESET    = 16'd30;

    // bit positions of the input word
    localparam int IN_TICK_BIT = 0;
    localparam int IN_EDGE_BIT = 1;

    typedef struct packed {
        logic take_item;
        logic start_avg;
        logic latch_avg;
        logic calc_diff;
        logic start_idx;
        logic latch_quot;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic update_due;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/mpab_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module mpab_div #(
    parameter int DW = 24,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [VW:0]   shifted;
    logic [VW:0]   trial;
    logic          fits;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        fits    = (shifted >= {1'b0, r_div});
        trial   = shifted - {1'b0, r_div};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CW'(DW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? trial[VW-1:0] : shifted[VW-1:0];
            n_quo = {r_quo[DW-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/mpab_dp.sv */
// datapath: period counter, running sum, config registers, divider and result register
// depends on mpab_pkg and mpab_div
module mpab_dp #(
    parameter int LED_COUNT    = mpab_pkg::LED_COUNT_DEF,
    parameter int COUNTER_BITS = mpab_pkg::COUNTER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpab_pkg::t_dp_cmd                   i_cmd,
    output mpab_pkg::t_dp_sts                   o_sts,
    input  logic                                i_tick,
    input  logic                                i_edge,
    input  logic                                i_cfg_we,
    input  logic [mpab_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpab_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [$clog2(LED_COUNT+1)-1:0]      o_led_index,
    output logic [LED_COUNT-1:0]                o_led_pattern,
    output logic [mpab_pkg::AVG_W-1:0]          o_average_count
);
    import mpab_pkg::*;

    localparam int SUM_W  = COUNTER_BITS + 8;
    localparam int IDX_W  = SUM_W + 2;
    localparam int LIDX_W = $clog2(LED_COUNT + 1);
    localparam logic [IDX_W-1:0] CENTER = IDX_W'((LED_COUNT + 1) / 2);
    localparam logic [IDX_W-1:0] LED_MAX = IDX_W'(LED_COUNT);

    logic [PERIODS_W-1:0]    r_periods;
    logic [NOMINAL_W-1:0]    r_nominal;
    logic [STEP_W-1:0]       r_step;
    logic [COUNTER_BITS-1:0] r_counter, n_counter;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [PERIODS_W-1:0]    r_seen, n_seen;
    logic [SUM_W-1:0]        r_avg;
    logic signed [SUM_W:0]   r_diff;
    logic [SUM_W-1:0]        r_quot;
    logic                    r_out_valid;
    logic [LIDX_W-1:0]       r_led_index;
    logic [LED_COUNT-1:0]    r_led_pattern;
    logic [AVG_W-1:0]        r_average;

    logic [SUM_W-1:0]     sum_new;
    logic [PERIODS_W-1:0] seen_new;
    logic [PERIODS_W-1:0] need;
    logic [STEP_W-1:0]    step_eff;
    logic                 update_due;
    logic [SUM_W:0]       diff_abs;
    logic                 div_start;
    logic [SUM_W-1:0]     div_dividend;
    logic [STEP_W-1:0]    div_divisor;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quot;
    logic [IDX_W-1:0]     idx;
    logic                 idx_ok;

    // a zero periods or step register value acts as one
    assign need     = (r_periods == '0) ? PERIODS_W'(1) : r_periods;
    assign step_eff = (r_step == '0) ? STEP_W'(1) : r_step;

    assign sum_new    = r_sum + SUM_W'(r_counter);
    assign seen_new   = r_seen + 1'b1;
    assign update_due = i_edge && (seen_new >= need);

    // the edge is handled before the tick of the same word
    always_comb begin
        n_counter = r_counter;
        n_sum     = r_sum;
        n_seen    = r_seen;
        if (i_cmd.take_item) begin
            if (i_edge) begin
                n_counter = '0;
                n_sum     = update_due ? '0 : sum_new;
                n_seen    = update_due ? '0 : seen_new;
            end
            if (i_tick) begin
                n_counter = (i_edge ? '0 : r_counter) + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_sum     <= '0;
            r_seen    <= '0;
            r_periods <= PERIODS_RESET;
            r_nominal <= NOMINAL_RESET;
            r_step    <= STEP_RESET;
        end else begin
            r_counter <= n_counter;
            r_sum     <= n_sum;
            r_seen    <= n_seen;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PERIODS: r_periods <= i_cfg_data[PERIODS_W-1:0];
                    CFG_NOMINAL: r_nominal <= i_cfg_data[NOMINAL_W-1:0];
                    CFG_STEP:    r_step    <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign diff_abs = r_diff[SUM_W] ? (-r_diff) : r_diff;

    // one divider serves the average and the led step
    assign div_start    = i_cmd.start_avg || i_cmd.start_idx;
    assign div_dividend = i_cmd.start_avg ? sum_new : diff_abs[SUM_W-1:0];
    assign div_divisor  = i_cmd.start_avg ? STEP_W'(need) : step_eff;

    mpab_div #(
        .DW (SUM_W),
        .VW (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // truncation toward zero: divide the magnitude, then restore the sign
    assign idx    = r_diff[SUM_W] ? (CENTER - {2'b00, r_quot}) : (CENTER + {2'b00, r_quot});
    assign idx_ok = !idx[IDX_W-1] && (idx != '0) && (idx <= LED_MAX);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_avg) begin
            r_avg <= div_quot;
        end
        if (i_cmd.calc_diff) begin
            r_diff <= $signed({1'b0, r_avg}) - $signed((SUM_W + 1)'(r_nominal));
        end
        if (i_cmd.latch_quot) begin
            r_quot <= div_quot;
        end
        if (i_cmd.load_out) begin
            r_led_index   <= idx_ok ? idx[LIDX_W-1:0] : '0;
            r_led_pattern <= idx_ok ? (LED_COUNT'(1) << (idx[LIDX_W-1:0] - 1'b1)) : '0;
            r_average     <= r_avg[AVG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.update_due = update_due;
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_led_index     = r_led_index;
    assign o_led_pattern   = r_led_pattern;
    assign o_average_count = r_average;

endmodule

/* rtl/mpab_ctrl.sv */
// controller: sequences one display update through the shared divider
// depends on mpab_pkg
module mpab_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mpab_pkg::t_dp_sts i_sts,
    output mpab_pkg::t_dp_cmd o_cmd
);
    import mpab_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV_AVG = 6'b000010,
        S_DIFF    = 6'b000100,
        S_START   = 6'b001000,
        S_DIV_IDX = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign take       = (r_state == S_IDLE) && i_in_valid;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && i_sts.update_due) n_state = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                if (i_sts.div_done) n_state = S_DIFF;
            end
            S_DIFF:  n_state = S_START;
            S_START: n_state = S_DIV_IDX;
            S_DIV_IDX: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.take_item  = take;
    assign o_cmd.start_avg  = take && i_sts.update_due;
    assign o_cmd.latch_avg  = (r_state == S_DIV_AVG) && i_sts.div_done;
    assign o_cmd.calc_diff  = (r_state == S_DIFF);
    assign o_cmd.start_idx  = (r_state == S_START);
    assign o_cmd.latch_quot = (r_state == S_DIV_IDX) && i_sts.div_done;
    assign o_cmd.load_out   = (r_state == S_OUT) && i_sts.out_free;

endmodule

/* rtl/mains_period_average_led_bargraph.sv */
// top level of the mains period averaging led bargraph
// depends on mpab_pkg, mpab_ctrl, mpab_dp (and mpab_div below it)
//
// usage:
//   input stream: one word per prescaled time step; bit 0 marks a timer tick,
//     bit 1 a rising mains edge (the edge is handled before the tick).
//   output stream: one word per display update: led index, one-hot (or empty) led bar
//     and the floor average period count behind it.
//   config channel: register index 0 periods per average, 1 nominal count, 2 counts
//     per led, always ready; user writes only while the block is idle, not enforced.
// timing:
//   a word that brings no update is taken, and the next one can follow at once.
//   a word that completes an average holds the input while the shared restoring
//   divider runs once for the average and once for the led step, one bit a cycle.
//   the result word is valid as the input opens again.
// reset clears counter, sum and period count, restores register defaults and
// empties the output register. a stalled receiver holds the output word; an
// update that finds it still full waits in its last step with the input closed.
module mains_period_average_led_bargraph #(
    parameter int LED_COUNT    = mpab_pkg::LED_COUNT_DEF,
    parameter int COUNTER_BITS = mpab_pkg::COUNTER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [0] timer_tick, [1] edge_seen, rest zero
    input  logic [mpab_pkg::IN_W-1:0]       i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // led_index, led_pattern, average_count from the lowest bit up, zero filled
    output logic [((($clog2(LED_COUNT+1) + LED_COUNT + mpab_pkg::AVG_W) + 7) / 8) * 8 - 1:0]
                                            o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mpab_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mpab_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mpab_pkg::*;

    localparam int LIDX_W = $clog2(LED_COUNT + 1);
    localparam int OUT_W  = ((LIDX_W + LED_COUNT + AVG_W + 7) / 8) * 8;

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [LIDX_W-1:0]    led_index;
    logic [LED_COUNT-1:0] led_pattern;
    logic [AVG_W-1:0]     average_count;

    assign o_cfg_ready = 1'b1;

    mpab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mpab_dp #(
        .LED_COUNT    (LED_COUNT),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_tick          (i_s_axis_tdata[IN_TICK_BIT]),
        .i_edge          (i_s_axis_tdata[IN_EDGE_BIT]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_led_index     (led_index),
        .o_led_pattern   (led_pattern),
        .o_average_count (average_count)
    );

    assign o_m_axis_tdata = OUT_W'({average_count, led_pattern, led_index});

endmodule
